FILE: hdl/fifo_page_replacement_top_defines.svh
// Assertion macros for the block's top-level RTL.
`ifndef FIFO_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define FIFO_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define FPR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define FPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

  // Width of the page number port and of the reported frame index.
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned FIDX_W  = 3;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned TOTAL_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the page and register the frame compare
    logic commit;   // resolve hit or fault, update frames and counters
  } fpr_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/fpr_ctrl.sv
`default_nettype none

module fpr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  output fpr_pkg::fpr_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.capture = start && (state_r == ST_IDLE);
  assign cmd.commit  = (state_r == ST_UPD);

endmodule

`default_nettype wire

FILE: hdl/fpr_dp.sv
`default_nettype none

module fpr_dp #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fpr_pkg::fpr_cmd_t             cmd,
  input  wire logic [fpr_pkg::PAGE_W-1:0]    in_page_number,
  input  wire logic                          cfg_we,
  input  wire logic [fpr_pkg::CFG_W-1:0]     cfg_frames_in_use,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [fpr_pkg::FIDX_W-1:0]         out_frame_index,
  output logic [fpr_pkg::TOTAL_W-1:0]        out_hit_total,
  output logic [fpr_pkg::TOTAL_W-1:0]        out_fault_total
);

  localparam int unsigned PW    = (PAGE_BITS < fpr_pkg::PAGE_W) ? PAGE_BITS : fpr_pkg::PAGE_W;
  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > fpr_pkg::CFG_W) ? CNT_W : fpr_pkg::CFG_W;
  localparam logic [fpr_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  logic [CMP_W-1:0]           cfg_r;
  logic [PW-1:0]              frame_r [FRAMES];
  logic [FRAMES-1:0]          valid_r;
  logic [IDX_W-1:0]           vp_r;
  logic [fpr_pkg::TOTAL_W-1:0] hit_cnt_r;
  logic [fpr_pkg::TOTAL_W-1:0] fault_cnt_r;
  logic [FRAMES-1:0]          match_r;
  logic [PW-1:0]              page_r;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [fpr_pkg::FIDX_W-1:0] out_fidx_r;

  logic [CNT_W-1:0]           active;
  logic [PW-1:0]              page_in;
  logic [FRAMES-1:0]          match_nxt;
  logic                       found;
  logic [IDX_W-1:0]           hit_slot;
  logic [IDX_W-1:0]           victim;
  logic [CNT_W:0]             victim_inc;
  logic [IDX_W-1:0]           vp_nxt;
  logic [IDX_W-1:0]           slot;
  logic [IDX_W+fpr_pkg::FIDX_W-1:0] slot_wide;

  // Clamp the frame count into 1..FRAMES.
  always_comb begin
    if (cfg_r == '0) begin
      active = CNT_W'(1);
    end else if (cfg_r > CMP_W'(FRAMES)) begin
      active = CNT_W'(FRAMES);
    end else begin
      active = cfg_r[CNT_W-1:0];
    end
  end

  assign page_in = in_page_number[PW-1:0];

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match_nxt[i] = valid_r[i] && (frame_r[i] == page_in) && (CNT_W'(i) < active);
    end
  end

  // Lowest matching frame wins.
  always_comb begin
    found    = |match_r;
    hit_slot = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_slot = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if ({1'b0, vp_r} >= (IDX_W + 1)'(active)) begin
      victim = '0;
    end else begin
      victim = vp_r;
    end
    victim_inc = (CNT_W + 1)'(victim) + (CNT_W + 1)'(1);
    if (victim_inc >= {1'b0, active}) begin
      vp_nxt = '0;
    end else begin
      vp_nxt = victim_inc[IDX_W-1:0];
    end
    slot      = found ? hit_slot : victim;
    slot_wide = {{fpr_pkg::FIDX_W{1'b0}}, slot};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CMP_W'(FRAMES);
      valid_r     <= '0;
      vp_r        <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= CMP_W'(cfg_frames_in_use);
      end
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        if (found) begin
          if (hit_cnt_r != TOTAL_MAX) begin
            hit_cnt_r <= hit_cnt_r + fpr_pkg::TOTAL_W'(1);
          end
        end else begin
          valid_r[victim] <= 1'b1;
          vp_r            <= vp_nxt;
          if (fault_cnt_r != TOTAL_MAX) begin
            fault_cnt_r <= fault_cnt_r + fpr_pkg::TOTAL_W'(1);
          end
        end
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r  <= page_in;
      match_r <= match_nxt;
    end
    if (cmd.commit) begin
      if (!found) begin
        frame_r[victim] <= page_r;
      end
      out_hit_r  <= found;
      out_fidx_r <= slot_wide[fpr_pkg::FIDX_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame_index = out_fidx_r;
  assign out_hit_total   = hit_cnt_r;
  assign out_fault_total = fault_cnt_r;

endmodule

`default_nettype wire

FILE: hdl/fifo_page_replacement_top.sv
`default_nettype none

// FIFO page replacement unit. Pulse start with a page number while busy is
// low; the reference is taken on that edge. After the commit cycle
// out_valid rises for exactly one cycle with hit, the frame that holds the
// page, and the saturating hit and fault totals that include this
// reference; the result is taken at the edge that ends that cycle. The
// receiver cannot stall: sample the result in the cycle out_valid is high.
// A reference is a compare against the frames in use, then a commit of the
// hit or the FIFO replacement; a new start is taken only while busy is low,
// and busy is high during the commit cycle only. Write cfg_frames_in_use
// with cfg_we only while no reference is in flight; 0 acts as 1 and values
// above FRAMES act as FRAMES. Only the low PAGE_BITS bits of a page take
// part.

`include "fifo_page_replacement_top_defines.svh"

module fifo_page_replacement_top #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input item
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [fpr_pkg::PAGE_W-1:0]    in_page_number,
  // frame count register
  input  wire logic                          cfg_we,
  input  wire logic [fpr_pkg::CFG_W-1:0]     cfg_frames_in_use,
  // result item
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [fpr_pkg::FIDX_W-1:0]         out_frame_index,
  output logic [fpr_pkg::TOTAL_W-1:0]        out_hit_total,
  output logic [fpr_pkg::TOTAL_W-1:0]        out_fault_total
);

  fpr_pkg::fpr_cmd_t cmd;

  // Sequence each reference: capture/compare, then commit.
  fpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold frames, valid bits, victim pointer, counters and result registers.
  fpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page_number    (in_page_number),
    .cfg_we            (cfg_we),
    .cfg_frames_in_use (cfg_frames_in_use),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_hit_total     (out_hit_total),
    .out_fault_total   (out_fault_total)
  );

  // An accepted item drives the commit cycle next.
  `FPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "accept without commit")
  // The result strobe follows the commit cycle, with the block free again.
  `FPR_ASSERT_SAME(a_result_idle, out_valid, !busy && $past(busy), "result without commit")
  // Results never come back to back.
  `FPR_ASSERT_NEXT(a_result_pulse, out_valid, !out_valid, "result strobe held")

endmodule

`default_nettype wire
